### rtl/sut_pkg.sv
// sut_pkg: shared types and constants for the sparse upper triangular solver.
// No dependencies.
`default_nettype none
package sut_pkg;
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_DIAG = 2'd1;
  localparam logic [1:0] STAT_ZERO    = 2'd2;

  localparam logic CMD_ENTRY = 1'b0;
  localparam logic CMD_EMPTY = 1'b1;

  localparam int AddrBits = 2;
  localparam logic [AddrBits-1:0] REG_UNIT = 2'd0;
  localparam logic [AddrBits-1:0] REG_ROWS = 2'd1;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_WAIT = 5'b10000
  } state_e;
endpackage
`default_nettype wire

### rtl/sut_ram.sv
// sut_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module sut_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/sut_div.sv
// sut_div: signed restoring divider, one quotient bit per cycle, truncating.
// Computes (num << Frac) / den. Depends on nothing.
`default_nettype none
module sut_div #(
  parameter int Width = 32,
  parameter int Frac  = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [Width-1:0] num_i,
  input  wire logic signed [Width-1:0] den_i,
  output logic                         done_o,
  output logic signed [Width-1:0]      quot_o
);
  localparam int NW = Width + Frac;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d, quo_q, quo_d;
  logic [Width:0] den_q, den_d;
  logic [Width:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [Width+1:0] trial;
  logic [NW:0] sq, mag;
  logic signed [NW+1:0] sv;
  logic signed [Width-1:0] hi_c, lo_c;

  assign hi_c = {1'b0, {(Width-1){1'b1}}};
  assign lo_c = {1'b1, {(Width-1){1'b0}}};
  assign trial = {rem_q, num_q[NW-1]} - {1'b0, den_q};

  always_comb begin
    num_d = num_q; quo_d = quo_q; den_d = den_q; rem_d = rem_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = (num_i[Width-1] ? NW'(-$signed({{Frac{1'b1}}, num_i}))
                              : NW'({{Frac{1'b0}}, num_i})) << Frac;
      den_d = den_i[Width-1] ? (Width+1)'(-$signed({1'b1, den_i}))
                             : {1'b0, den_i};
      neg_d = num_i[Width-1] ^ den_i[Width-1];
      rem_d = '0; quo_d = '0; cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Width+1]) begin
        rem_d = trial[Width:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-1:0], num_q[NW-1]};
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      num_d = {num_q[NW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; den_q <= den_d; rem_q <= rem_d; neg_q <= neg_d;
  end

  // magnitude fits NW bits; apply sign then saturate
  assign mag = {1'b0, quo_q};
  assign sq  = neg_q ? -mag : mag;
  assign sv  = $signed({sq[NW], sq});
  always_comb begin
    if (sv > $signed((NW+2)'(hi_c))) quot_o = hi_c;
    else if (sv < $signed({{(NW+2-Width){1'b1}}, lo_c})) quot_o = lo_c;
    else quot_o = sv[Width-1:0];
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

### rtl/sparse_upper_triangular_solve_top.sv
// Sparse upper triangular solver top: sequencer, MAC datapath, solution RAM.
// Depends on sut_pkg, sut_ram, sut_div.
// An entry goes through a RAM read, then a multiply-accumulate.
// A closing item then goes through the bit-serial divider, or skips it when no
// division is needed, and then through ST_OUT before the word is offered.
// One item at a time. Reset clears control state; the RAM is not cleared.
`default_nettype none
module sparse_upper_triangular_solve_top #(
  parameter int MAX_ROWS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [9:0]  row_index_i,
  input  wire logic [9:0]  col_index_i,
  input  wire logic signed [31:0] entry_value_i,
  input  wire logic signed [31:0] rhs_value_i,
  input  wire logic        last_in_row_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       out_row_o,
  output logic signed [31:0] solution_value_o,
  output logic [1:0]       status_o,
  output logic             last_row_o
);
  localparam int VW = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 16) ? 16 : VALUE_BITS);
  localparam int FB = VW - 8;
  localparam int AW = $clog2(MAX_ROWS);
  localparam int PW = 2 * VW;

  logic unit_q;
  logic [10:0] rows_q;
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b0; rows_q <= 11'd1024;
    end else if (wr_en) begin
      if (paddr[2] == sut_pkg::REG_ROWS[0]) rows_q <= pwdata[10:0];
      else unit_q <= pwdata[0];
    end
  end
  assign prdata = paddr[2] ? {21'd0, rows_q} : {31'd0, unit_q};

  // saturate a 32-bit field to VW
  function automatic logic signed [VW-1:0] sat_in(input logic signed [31:0] v);
    logic signed [31:0] hi, lo;
    hi = 32'(((64'sd1) <<< (VW - 1)) - 1);
    lo = -hi - 32'sd1;
    if (v > hi) return hi[VW-1:0];
    if (v < lo) return lo[VW-1:0];
    return v[VW-1:0];
  endfunction

  sut_pkg::state_e st_q, st_d;
  logic open_q, seen_q;
  logic [9:0] orow_q;
  logic signed [VW-1:0] acc_q, diag_q, ent_q, sol_q;
  logic use_q, last_q;
  logic [1:0] stat_q;
  logic accept, ovld_q;
  logic signed [VW-1:0] rd;
  logic signed [PW-1:0] prod;
  logic signed [PW:0] term;
  logic div_start, div_done;
  logic signed [VW-1:0] quot;
  logic [9:0] row_eff;
  logic signed [VW-1:0] acc_eff;
  logic store_en;
  logic diag_hit;
  logic signed [VW-1:0] acc_nxt, sol_nxt;
  logic [1:0] stat_nxt;

  assign in_stall_o = (st_q != sut_pkg::ST_IDLE);
  assign accept = in_valid_i & ~in_stall_o;
  assign row_eff = open_q ? orow_q : row_index_i;
  assign acc_eff = open_q ? acc_q : sat_in(rhs_value_i);
  assign diag_hit = (cmd_i == sut_pkg::CMD_ENTRY) && 11'(col_index_i) < rows_q
                    && 32'(col_index_i) < MAX_ROWS && col_index_i == row_eff;

  sut_ram #(.Width(VW), .Depth(MAX_ROWS)) u_ram (
    .clk_i, .we_i(store_en), .waddr_i(AW'(orow_q)), .wdata_i(sol_q),
    .raddr_i(AW'(col_index_i)), .rdata_o(rd)
  );

  assign prod = PW'(ent_q) * PW'(rd);
  assign term = ($signed({prod[PW-1], prod}) + ((PW+1)'(1) <<< (FB - 1))) >>> FB;

  // divider takes the sum including the row's final entry
  sut_div #(.Width(VW), .Frac(FB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(acc_nxt), .den_i(diag_q),
    .done_o(div_done), .quot_o(quot)
  );

  logic signed [VW-1:0] maxv, minv;
  assign maxv = {1'b0, {(VW-1){1'b1}}};
  assign minv = {1'b1, {(VW-1){1'b0}}};
  // term may exceed diff width; clamp on the wide difference
  logic signed [PW+1:0] dwide;
  assign dwide = (PW+2)'(acc_q) - (PW+2)'(term);

  always_comb begin
    acc_nxt = acc_q;
    if (use_q) begin
      if (dwide > (PW+2)'(maxv)) acc_nxt = maxv;
      else if (dwide < (PW+2)'(minv)) acc_nxt = minv;
      else acc_nxt = dwide[VW-1:0];
    end
  end

  always_comb begin
    sol_nxt = acc_nxt;
    stat_nxt = sut_pkg::STAT_OK;
    if (!unit_q && !seen_q) stat_nxt = sut_pkg::STAT_NO_DIAG;
    else if (!unit_q && diag_q == '0) begin
      stat_nxt = sut_pkg::STAT_ZERO; sol_nxt = '0;
    end
  end

  always_comb begin
    st_d = st_q;
    div_start = 1'b0;
    unique case (st_q)
      sut_pkg::ST_IDLE: if (accept) st_d = sut_pkg::ST_MAC;
      sut_pkg::ST_MAC:
        if (!last_q) st_d = sut_pkg::ST_IDLE;
        else if (!unit_q && seen_q && diag_q != '0) begin
          st_d = sut_pkg::ST_DIV; div_start = 1'b1;
        end else st_d = sut_pkg::ST_OUT;
      sut_pkg::ST_DIV: if (div_done) st_d = sut_pkg::ST_OUT;
      sut_pkg::ST_OUT: st_d = sut_pkg::ST_WAIT;
      sut_pkg::ST_WAIT: if (!ovld_q || !out_stall_i) st_d = sut_pkg::ST_IDLE;
      default: st_d = sut_pkg::ST_IDLE;
    endcase
  end
  assign store_en = (st_q == sut_pkg::ST_OUT) && (32'(orow_q) < MAX_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sut_pkg::ST_IDLE; open_q <= 1'b0; seen_q <= 1'b0; ovld_q <= 1'b0;
      acc_q <= '0; diag_q <= '0; orow_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == sut_pkg::ST_OUT) ovld_q <= 1'b1;
      else if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      unique case (st_q)
        sut_pkg::ST_IDLE: if (accept) begin
          open_q <= 1'b1;
          orow_q <= row_eff;
          acc_q <= acc_eff;
          seen_q <= diag_hit | (open_q & seen_q);
          if (diag_hit) diag_q <= sat_in(entry_value_i);
        end
        sut_pkg::ST_MAC: acc_q <= acc_nxt;
        sut_pkg::ST_OUT: begin
          open_q <= 1'b0; seen_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == sut_pkg::ST_IDLE && accept) begin
      ent_q <= sat_in(entry_value_i);
      last_q <= last_in_row_i | (cmd_i == sut_pkg::CMD_EMPTY);
      use_q <= (cmd_i == sut_pkg::CMD_ENTRY) && 11'(col_index_i) < rows_q
               && 32'(col_index_i) < MAX_ROWS && col_index_i > row_eff;
    end
    if (st_q == sut_pkg::ST_DIV && div_done) begin
      sol_q <= quot; stat_q <= sut_pkg::STAT_OK;
    end else if (st_q == sut_pkg::ST_MAC && last_q) begin
      sol_q <= sol_nxt; stat_q <= stat_nxt;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_row_o = orow_q;
  assign solution_value_o = 32'(sol_q);
  assign status_o = stat_q;
  assign last_row_o = (orow_q == 10'd0);

  // divider result must only arrive while dividing
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == sut_pkg::ST_DIV) else $error("stray divider result");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && out_stall_i |=> ovld_q) else $error("result word dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
endmodule
`default_nettype wire
